[src/tcn3d_pkg.sv]
`timescale 1ns / 1ps
// Package for the tiling 3-D cellular noise block: widths, constants and the
// structs passed between the top level, the cell pipeline and the finishing unit.
`default_nettype none

package tcn3d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_FREQ  = 256;
    localparam int COORD_W   = 24;
    localparam int FREQ_W    = 9;
    localparam int CELL_W    = 8;
    localparam int DIST_W    = 36;
    localparam int ROOT_W    = 18;
    localparam int OUT_W     = 17;

    // Offset codes of a neighbour cell along one axis.
    localparam logic [1:0] OFF_NEG  = 2'd0;
    localparam logic [1:0] OFF_ZERO = 2'd1;
    localparam logic [1:0] OFF_POS  = 2'd2;

    // Register indexes of the configuration port.
    localparam logic REG_FREQ = 1'b0;
    localparam logic REG_MODE = 1'b1;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 9'd4;
    localparam logic              MODE_RESET = 1'b1;

    // Hash constants.
    localparam logic [31:0] HX  = 32'd1619;
    localparam logic [31:0] HY  = 32'd31337;
    localparam logic [31:0] HZ  = 32'd6271;
    localparam logic [31:0] HS  = 32'd1013;
    localparam logic [31:0] HM1 = 32'hb5297a4d;
    localparam logic [31:0] HM2 = 32'h68e31da4;

    // Starting value of both distances: 9.0 with 32 fraction bits.
    localparam logic [DIST_W-1:0] DIST_INIT = 36'h9_0000_0000;

    // Division by 1.73205: reciprocal with 32 fraction bits plus a correction.
    localparam logic [31:0] RECIP    = 32'((64'd1 << 32) * 64'd100000 / 64'd173205);
    localparam logic [17:0] SQ3_NUM  = 18'd100000;
    localparam logic [17:0] SQ3_DEN  = 18'd173205;
    localparam logic [OUT_W-1:0] OUT_ONE = 17'd65536;

    // One neighbour cell handed to the pipeline.
    typedef struct packed {
        logic                    valid;
        logic [CELL_W-1:0]       x;
        logic [CELL_W-1:0]       y;
        logic [CELL_W-1:0]       z;
        logic [2:0][1:0]         off;
        logic [2:0][FRAC_BITS-1:0] fr;
        logic                    first;
        logic                    last;
    } cell_cmd_t;

    // Nearest and second nearest squared distance of one finished item.
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] m1;
        logic [DIST_W-1:0] m2;
    } dist_pair_t;

    // Result and status of the finishing unit.
    typedef struct packed {
        logic             valid;
        logic             busy;
        logic [OUT_W-1:0] value;
    } fin_status_t;

endpackage

`default_nettype wire

[src/tcn3d_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and the noise output.
// Depends on tcn3d_pkg for the field widths.
`default_nettype none

interface tcn3d_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [tcn3d_pkg::COORD_W-1:0]   px;
    logic signed [tcn3d_pkg::COORD_W-1:0]   py;
    logic signed [tcn3d_pkg::COORD_W-1:0]   pz;
    modport source (output valid, px, py, pz, input ready);
    modport sink   (input valid, px, py, pz, output ready);
endinterface

interface tcn3d_out_if;
    logic                           valid;
    logic                           ready;
    logic [tcn3d_pkg::OUT_W-1:0]    noise_value;
    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

`default_nettype wire

[src/tcn3d_cell_pipe.sv]
`timescale 1ns / 1ps
// Cell pipeline: hashes one neighbour cell per cycle while en is high, forms its
// squared distance and keeps the two smallest per item. Depends on tcn3d_pkg.
`default_nettype none

module tcn3d_cell_pipe (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  tcn3d_pkg::cell_cmd_t     cmd,
    output tcn3d_pkg::dist_pair_t    pair
);

    typedef struct packed {
        logic                                  valid;
        logic [2:0][1:0]                       off;
        logic [2:0][tcn3d_pkg::FRAC_BITS-1:0]  fr;
        logic                                  first;
        logic                                  last;
    } meta_t;

    meta_t meta1_reg, meta2_reg, meta3_reg, meta4_reg, meta5_reg;
    logic [31:0] n1_reg [3];
    logic [31:0] n2_reg [3];
    logic [31:0] n3_reg [3];
    logic [33:0] sq_reg [3];
    logic [tcn3d_pkg::DIST_W-1:0] d_reg;
    logic [tcn3d_pkg::DIST_W-1:0] m1_reg, m2_reg, m1_next, m2_next;
    logic pair_valid_reg;

    logic [31:0] base;
    logic [31:0] t2 [3];
    logic [31:0] t3 [3];
    logic [31:0] t4 [3];
    logic [15:0] h [3];
    logic signed [18:0] diff [3];
    logic [16:0] mag [3];

    meta_t meta0;
    assign meta0.valid = cmd.valid;
    assign meta0.off   = cmd.off;
    assign meta0.fr    = cmd.fr;
    assign meta0.first = cmd.first;
    assign meta0.last  = cmd.last;

    // Stage 1: salted coordinate mix.
    assign base = (32'(cmd.x) * tcn3d_pkg::HX) ^ (32'(cmd.y) * tcn3d_pkg::HY)
                ^ (32'(cmd.z) * tcn3d_pkg::HZ);

    // Stages 2 to 4: avalanche rounds, then distance along each axis.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            t2[a] = n1_reg[a] ^ (n1_reg[a] >> 13);
            t3[a] = n2_reg[a] ^ (n2_reg[a] >> 7);
            t4[a] = n3_reg[a] ^ (n3_reg[a] >> 11);
            h[a]  = t4[a][23:8];
            diff[a] = $signed({3'b000, h[a]}) - $signed({3'b000, meta3_reg.fr[a]});
            if (meta3_reg.off[a] == tcn3d_pkg::OFF_NEG)
            begin
                diff[a] = diff[a] - 19'sd65536;
            end
            else if (meta3_reg.off[a] == tcn3d_pkg::OFF_POS)
            begin
                diff[a] = diff[a] + 19'sd65536;
            end
            mag[a] = diff[a][18] ? 17'(-diff[a]) : 17'(diff[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                n1_reg[a] <= base ^ (32'(a) * tcn3d_pkg::HS);
                n2_reg[a] <= t2[a] * tcn3d_pkg::HM1;
                n3_reg[a] <= t3[a] * tcn3d_pkg::HM2;
                sq_reg[a] <= 34'(mag[a]) * 34'(mag[a]);
            end
            d_reg <= 36'(sq_reg[0]) + 36'(sq_reg[1]) + 36'(sq_reg[2]);
        end
    end

    // Item tags travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta1_reg <= '0;
            meta2_reg <= '0;
            meta3_reg <= '0;
            meta4_reg <= '0;
            meta5_reg <= '0;
        end
        else if (en)
        begin
            meta1_reg <= meta0;
            meta2_reg <= meta1_reg;
            meta3_reg <= meta2_reg;
            meta4_reg <= meta3_reg;
            meta5_reg <= meta4_reg;
        end
    end

    // Stage 6: keep the two smallest; ties leave the earlier cell in place.
    always_comb
    begin
        logic [tcn3d_pkg::DIST_W-1:0] b1, b2;
        b1 = meta5_reg.first ? tcn3d_pkg::DIST_INIT : m1_reg;
        b2 = meta5_reg.first ? tcn3d_pkg::DIST_INIT : m2_reg;
        m1_next = b1;
        m2_next = b2;
        if (d_reg < b1)
        begin
            m1_next = d_reg;
            m2_next = b1;
        end
        else if (d_reg < b2)
        begin
            m2_next = d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && meta5_reg.valid)
        begin
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            pair_valid_reg <= meta5_reg.valid && meta5_reg.last;
        end
    end

    assign pair.valid = pair_valid_reg;
    assign pair.m1    = m1_reg;
    assign pair.m2    = m2_reg;

endmodule

`default_nettype wire

[src/tcn3d_finish.sv]
`timescale 1ns / 1ps
// Finishing unit: square roots of both distances, two radicand bits per enabled
// cycle, then scaling by 1/sqrt(3) and the clamp per mode. Depends on tcn3d_pkg.
`default_nettype none

module tcn3d_finish (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      en,
    input  wire                      mode,
    input  tcn3d_pkg::dist_pair_t    pair,
    output tcn3d_pkg::fin_status_t   status
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_SEL  = 3'd2;
    localparam logic [2:0] ST_QUO  = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_FIX  = 3'd5;

    localparam int RW = tcn3d_pkg::ROOT_W;

    logic [2:0]  state_reg;
    logic [4:0]  cnt_reg;
    logic [tcn3d_pkg::DIST_W-1:0] rad_reg [2];
    logic [RW+1:0] rem_reg [2];
    logic [RW-1:0] root_reg [2];
    logic [RW-1:0] s_reg, q0_reg;
    logic [35:0]   t1_reg, t2_reg;

    logic [RW+3:0] rem_t [2];
    logic [RW+3:0] trial [2];
    logic [49:0]   prod;
    logic [35:0]   rdiff;
    logic [RW-1:0] q;
    logic [tcn3d_pkg::OUT_W-1:0] result;

    // One root digit per cycle for each distance while enabled.
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            rem_t[k] = {rem_reg[k], rad_reg[k][tcn3d_pkg::DIST_W-1 -: 2]};
            trial[k] = {2'b00, root_reg[k], 2'b01};
        end
    end

    assign prod  = 50'(s_reg) * 50'(tcn3d_pkg::RECIP);
    assign rdiff = t1_reg - t2_reg;
    assign q     = (rdiff >= 36'(tcn3d_pkg::SQ3_DEN)) ? q0_reg + 1'b1 : q0_reg;

    // Clamp into Q1.16 for the selected mode.
    always_comb
    begin
        if (!mode)
        begin
            result = (q >= RW'(tcn3d_pkg::OUT_ONE)) ? '0 : tcn3d_pkg::OUT_ONE - q[16:0];
        end
        else
        begin
            result = (q > RW'(tcn3d_pkg::OUT_ONE)) ? tcn3d_pkg::OUT_ONE : q[16:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else if (en)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (pair.valid)
                    begin
                        state_reg <= ST_ROOT;
                        cnt_reg   <= '0;
                    end
                end
                ST_ROOT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'(RW - 1))
                    begin
                        state_reg <= ST_SEL;
                    end
                end
                ST_SEL:  state_reg <= ST_QUO;
                ST_QUO:  state_reg <= ST_CHK;
                ST_CHK:  state_reg <= ST_FIX;
                ST_FIX:  state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (state_reg == ST_IDLE && pair.valid)
            begin
                rad_reg[0]  <= pair.m1;
                rad_reg[1]  <= pair.m2;
                rem_reg[0]  <= '0;
                rem_reg[1]  <= '0;
                root_reg[0] <= '0;
                root_reg[1] <= '0;
            end
            else if (state_reg == ST_ROOT)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    rad_reg[k] <= rad_reg[k] << 2;
                    if (rem_t[k] >= trial[k])
                    begin
                        rem_reg[k]  <= (RW + 2)'(rem_t[k] - trial[k]);
                        root_reg[k] <= {root_reg[k][RW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[k]  <= (RW + 2)'(rem_t[k]);
                        root_reg[k] <= {root_reg[k][RW-2:0], 1'b0};
                    end
                end
            end
            if (state_reg == ST_SEL)
            begin
                if (!mode)
                begin
                    s_reg <= root_reg[0];
                end
                else
                begin
                    s_reg <= (root_reg[1] >= root_reg[0]) ? root_reg[1] - root_reg[0] : '0;
                end
            end
            if (state_reg == ST_QUO)
            begin
                q0_reg <= prod[49:32];
            end
            if (state_reg == ST_CHK)
            begin
                t1_reg <= 36'(s_reg) * 36'(tcn3d_pkg::SQ3_NUM);
                t2_reg <= 36'(q0_reg) * 36'(tcn3d_pkg::SQ3_DEN);
            end
        end
    end

    assign status.valid = (state_reg == ST_FIX);
    assign status.busy  = (state_reg != ST_IDLE);
    assign status.value = result;

endmodule

`default_nettype wire

[src/tiling_cellular_noise_3d.sv]
`timescale 1ns / 1ps
// Top level of the tiling 3-D cellular noise block: configuration registers,
// cell index front end, neighbour sequencer and output register.
// Depends on tcn3d_pkg, tcn3d_if, tcn3d_cell_pipe and tcn3d_finish.
//
//  Channel     Direction  Carries
//  sample_in   in         px, py, pz (signed Q8.16)
//  noise_out   out        noise_value (Q1.16)
//  APB port    in         frequency (0x0), mode (0x4)
//
// An item is read one neighbour cell per cycle through the cell pipeline while the
// output is not stalled; the sequencer issuing those cells sets the rate. An item
// passes the index front end, the neighbour cells, the 6 cell pipeline stages and
// the roots and scaling. Reset clears all control state; there is no clearing pass.
// A stalled output freezes every stage at once, so nothing is lost or repeated.
`default_nettype none

module tiling_cellular_noise_3d (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [31:0]          pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    tcn3d_in_if.sink            sample_in,
    tcn3d_out_if.source         noise_out
);

    localparam logic [4:0] FR_MUL  = 5'd0;
    localparam logic [4:0] FR_DONE = 5'd17;

    logic [tcn3d_pkg::FREQ_W-1:0] freq_reg;
    logic                         mode_reg;
    logic [tcn3d_pkg::FREQ_W-1:0] pe;
    logic                         en;

    // Front end registers.
    logic        front_busy_reg;
    logic [4:0]  front_cnt_reg;
    logic signed [tcn3d_pkg::COORD_W-1:0] pin_reg [3];
    logic [15:0] mag_reg [3];
    logic        neg_reg [3];
    logic [tcn3d_pkg::FRAC_BITS-1:0] frac_reg [3];
    logic [8:0]  rem_reg [3];

    // Sequencer registers.
    logic        seq_busy_reg;
    logic [1:0]  cx_reg, cy_reg, cz_reg;
    logic [tcn3d_pkg::CELL_W-1:0] nbr_reg [3][3];
    logic [tcn3d_pkg::FRAC_BITS-1:0] sfr_reg [3];
    tcn3d_pkg::cell_cmd_t cmd_reg;

    logic        out_valid_reg;
    logic [tcn3d_pkg::OUT_W-1:0] out_value_reg;

    logic signed [33:0] prod [3];
    logic signed [17:0] cidx [3];
    logic [9:0]  r2 [3];
    logic [8:0]  w [3];
    logic [8:0]  lo [3];
    logic [8:0]  hi [3];
    logic        seq_last;
    logic        handoff;

    tcn3d_pkg::dist_pair_t  pair;
    tcn3d_pkg::fin_status_t fin;

    // Configuration port.
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= tcn3d_pkg::FREQ_RESET;
            mode_reg <= tcn3d_pkg::MODE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                tcn3d_pkg::REG_FREQ: freq_reg <= pwdata[8:0];
                tcn3d_pkg::REG_MODE: mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            tcn3d_pkg::REG_FREQ: prdata = {23'd0, freq_reg};
            tcn3d_pkg::REG_MODE: prdata = {31'd0, mode_reg};
            default:             prdata = '0;
        endcase
    end

    // Effective period: zero counts as one, large values saturate.
    always_comb
    begin
        if (freq_reg == '0)
        begin
            pe = 9'd1;
        end
        else if (freq_reg > 9'(tcn3d_pkg::MAX_FREQ))
        begin
            pe = 9'(tcn3d_pkg::MAX_FREQ);
        end
        else
        begin
            pe = freq_reg;
        end
    end

    // Every stage moves unless a finished item is waiting at the output.
    assign en = !out_valid_reg || noise_out.ready;

    assign sample_in.ready = !front_busy_reg;

    // Scaling, floor split, one remainder bit per enabled cycle for each axis, and the wrapped neighbour indexes.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            prod[a] = pin_reg[a] * $signed({25'd0, pe});
            cidx[a] = prod[a][33:16];
            r2[a]   = {rem_reg[a], mag_reg[a][15]};
            w[a]    = (neg_reg[a] && rem_reg[a] != '0) ? pe - rem_reg[a] : rem_reg[a];
            lo[a]   = (w[a] == '0) ? pe - 9'd1 : w[a] - 9'd1;
            hi[a]   = (w[a] == pe - 9'd1) ? '0 : w[a] + 9'd1;
        end
    end

    assign seq_last = (cx_reg == tcn3d_pkg::OFF_POS) && (cy_reg == tcn3d_pkg::OFF_POS)
                   && (cz_reg == tcn3d_pkg::OFF_POS);
    assign handoff  = en && front_busy_reg && (front_cnt_reg == FR_DONE)
                   && (!seq_busy_reg || seq_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_busy_reg <= 1'b0;
            front_cnt_reg  <= FR_MUL;
        end
        else if (sample_in.valid && sample_in.ready)
        begin
            front_busy_reg <= 1'b1;
            front_cnt_reg  <= FR_MUL;
        end
        else if (handoff)
        begin
            front_busy_reg <= 1'b0;
        end
        else if (en && front_busy_reg && front_cnt_reg != FR_DONE)
        begin
            front_cnt_reg <= front_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            pin_reg[0] <= sample_in.px;
            pin_reg[1] <= sample_in.py;
            pin_reg[2] <= sample_in.pz;
        end
        else if (en && front_busy_reg)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (front_cnt_reg == FR_MUL)
                begin
                    neg_reg[a]  <= cidx[a][17];
                    mag_reg[a]  <= cidx[a][17] ? 16'(-cidx[a]) : 16'(cidx[a]);
                    frac_reg[a] <= prod[a][15:0];
                    rem_reg[a]  <= '0;
                end
                else if (front_cnt_reg != FR_DONE)
                begin
                    mag_reg[a] <= mag_reg[a] << 1;
                    rem_reg[a] <= (r2[a] >= {1'b0, pe}) ? 9'(r2[a] - {1'b0, pe}) : r2[a][8:0];
                end
            end
        end
    end

    // Neighbour sequencer: dz innermost, then dy, then dx.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_busy_reg <= 1'b0;
            cx_reg       <= tcn3d_pkg::OFF_NEG;
            cy_reg       <= tcn3d_pkg::OFF_NEG;
            cz_reg       <= tcn3d_pkg::OFF_NEG;
            cmd_reg      <= '0;
        end
        else if (en)
        begin
            cmd_reg.valid <= seq_busy_reg;
            cmd_reg.x     <= nbr_reg[0][cx_reg];
            cmd_reg.y     <= nbr_reg[1][cy_reg];
            cmd_reg.z     <= nbr_reg[2][cz_reg];
            cmd_reg.off   <= {cz_reg, cy_reg, cx_reg};
            cmd_reg.fr    <= {sfr_reg[2], sfr_reg[1], sfr_reg[0]};
            cmd_reg.first <= (cx_reg == tcn3d_pkg::OFF_NEG) && (cy_reg == tcn3d_pkg::OFF_NEG)
                          && (cz_reg == tcn3d_pkg::OFF_NEG);
            cmd_reg.last  <= seq_last;
            if (handoff)
            begin
                seq_busy_reg <= 1'b1;
                cx_reg       <= tcn3d_pkg::OFF_NEG;
                cy_reg       <= tcn3d_pkg::OFF_NEG;
                cz_reg       <= tcn3d_pkg::OFF_NEG;
            end
            else if (seq_busy_reg)
            begin
                if (seq_last)
                begin
                    seq_busy_reg <= 1'b0;
                    cx_reg       <= tcn3d_pkg::OFF_NEG;
                    cy_reg       <= tcn3d_pkg::OFF_NEG;
                    cz_reg       <= tcn3d_pkg::OFF_NEG;
                end
                else if (cz_reg != tcn3d_pkg::OFF_POS)
                begin
                    cz_reg <= cz_reg + 1'b1;
                end
                else
                begin
                    cz_reg <= tcn3d_pkg::OFF_NEG;
                    if (cy_reg != tcn3d_pkg::OFF_POS)
                    begin
                        cy_reg <= cy_reg + 1'b1;
                    end
                    else
                    begin
                        cy_reg <= tcn3d_pkg::OFF_NEG;
                        cx_reg <= cx_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (handoff)
        begin
            for (int a = 0; a < 3; a++)
            begin
                nbr_reg[a][tcn3d_pkg::OFF_NEG]  <= lo[a][7:0];
                nbr_reg[a][tcn3d_pkg::OFF_ZERO] <= w[a][7:0];
                nbr_reg[a][tcn3d_pkg::OFF_POS]  <= hi[a][7:0];
                sfr_reg[a]                      <= frac_reg[a];
            end
        end
    end

    tcn3d_cell_pipe u_pipe (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .cmd   (cmd_reg),
        .pair  (pair)
    );

    tcn3d_finish u_finish (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .mode   (mode_reg),
        .pair   (pair),
        .status (fin)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && fin.valid)
        begin
            out_value_reg <= fin.value;
        end
    end

    assign noise_out.valid       = out_valid_reg;
    assign noise_out.noise_value = out_value_reg;

    // A finished distance pair only ever reaches an idle finishing unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pair.valid && en) |-> !fin.busy)
        else $error("distance pair arrived while finishing unit busy");

    // A ready front end hands its item over when the sequencer is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (en && front_busy_reg && front_cnt_reg == FR_DONE && !seq_busy_reg)
        |=> !front_busy_reg || $past(sample_in.valid && sample_in.ready))
        else $error("front end failed to hand off to idle sequencer");

    // The sequencer never marks one cell both first and last.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_reg.valid && cmd_reg.first) |-> !cmd_reg.last)
        else $error("cell marked both first and last");

endmodule

`default_nettype wire
